// ===== rtl/calendar_clock_bcd_unit_macros.svh =====
// Assertion macros shared by the calendar clock RTL.
// Each macro samples on posedge clk and is disabled while rst_n is low.
`ifndef CALENDAR_CLOCK_BCD_UNIT_MACROS_SVH
`define CALENDAR_CLOCK_BCD_UNIT_MACROS_SVH

`ifndef SYNTHESIS
`define CCBCD_ASSERT_ALWAYS(lbl, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);
`define CCBCD_ASSERT_IMPLIES(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
`define CCBCD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define CCBCD_ASSERT_ALWAYS(lbl, expr, msg)
`define CCBCD_ASSERT_IMPLIES(lbl, ante, cons, msg)
`define CCBCD_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

// ===== rtl/ccbcd_pkg.sv =====
// Package for the calendar clock: request and time types, codes, BCD helpers.
// No dependencies.
`timescale 1ns / 1ps

package ccbcd_pkg;

    localparam logic OP_TICK = 1'b0;
    localparam logic OP_LOAD = 1'b1;

    localparam logic [2:0] REG_TPS_ADDR = 3'd0;
    localparam logic [7:0] TPS_RESET    = 8'd4;

    localparam logic [13:0] YEAR_MAX   = 14'd9999;
    localparam logic [3:0]  MONTH_MAX  = 4'd12;
    localparam logic [4:0]  HOUR_MAX   = 5'd23;
    localparam logic [5:0]  MINSEC_MAX = 6'd59;

    // Load request after clamping; the year is split into its two halves.
    typedef struct packed {
        logic       opcode;
        logic [6:0] year_hi;
        logic [6:0] year_lo;
        logic [3:0] month;
        logic [4:0] day;
        logic [4:0] hour;
        logic [5:0] minute;
        logic [5:0] second;
    } ccbcd_load_t;

    // Date and time, packed BCD.
    typedef struct packed {
        logic [15:0] year;
        logic [7:0]  month;
        logic [7:0]  day;
        logic [7:0]  hour;
        logic [7:0]  minute;
        logic [7:0]  second;
    } ccbcd_time_t;

    // 0..99 to two BCD digits; tens = (v * 103) >> 10 is exact below 100.
    function automatic logic [7:0] bin_to_bcd2(input logic [6:0] v);
        logic [13:0] prod;
        logic [3:0]  tens;
        logic [6:0]  ones;
        prod = {7'b0, v} * 14'd103;
        tens = prod[13:10];
        ones = v - ({3'b0, tens} << 3) - ({3'b0, tens} << 1);
        return {tens, ones[3:0]};
    endfunction

    function automatic logic [7:0] bcd_inc2(input logic [7:0] b);
        logic [7:0] r;
        if (b[3:0] == 4'd9) begin
            r = {b[7:4] + 4'd1, 4'd0};
        end else begin
            r = {b[7:4], b[3:0] + 4'd1};
        end
        return r;
    endfunction

    function automatic logic [15:0] bcd_inc4(input logic [15:0] b);
        logic [15:0] r;
        logic        carry;
        r     = b;
        carry = 1'b1;
        for (int i = 0; i < 4; i++) begin
            if (carry) begin
                if (b[4*i +: 4] == 4'd9) begin
                    r[4*i +: 4] = 4'd0;
                end else begin
                    r[4*i +: 4] = b[4*i +: 4] + 4'd1;
                    carry       = 1'b0;
                end
            end
        end
        return r;
    endfunction

    // Two-digit BCD value divisible by 4: (2*tens + ones) mod 4 == 0.
    function automatic logic bcd2_div4(input logic [7:0] b);
        logic [1:0] s;
        s = b[1:0] + {b[4], 1'b0};
        return (s == 2'd0);
    endfunction

    function automatic logic is_leap(input logic [15:0] y);
        return ((y[7:0] != 8'h00) && bcd2_div4(y[7:0])) ||
               ((y[7:0] == 8'h00) && bcd2_div4(y[15:8]));
    endfunction

    function automatic logic [7:0] month_days(input logic [7:0] m, input logic leap);
        logic [7:0] d;
        case (m) inside
            8'h04, 8'h06, 8'h09, 8'h11: d = 8'h30;
            8'h02:                      d = leap ? 8'h29 : 8'h28;
            default:                    d = 8'h31;
        endcase
        return d;
    endfunction

endpackage

// ===== rtl/ccbcd_load_prep.sv =====
// Load request preparation: clamps each field into range, splits the year
// into hundreds and remainder. Uses ccbcd_pkg.
`timescale 1ns / 1ps

module ccbcd_load_prep
    import ccbcd_pkg::*;
(
    input  logic        opcode,
    input  logic [13:0] load_year,
    input  logic [3:0]  load_month,
    input  logic [4:0]  load_day,
    input  logic [4:0]  load_hour,
    input  logic [5:0]  load_minute,
    input  logic [5:0]  load_second,
    output ccbcd_load_t item
);

    logic [13:0] year_c;
    logic [26:0] year_prod;
    logic [6:0]  year_hi;
    logic [13:0] year_hund;
    logic [13:0] year_rem;

    assign year_c    = (load_year > YEAR_MAX) ? YEAR_MAX : load_year;
    // year / 100 as (year * 5243) >> 19, exact up to 9999
    assign year_prod = {13'b0, year_c} * 27'd5243;
    assign year_hi   = year_prod[25:19];
    assign year_hund = {7'b0, year_hi} * 14'd100;
    assign year_rem  = year_c - year_hund;

    always_comb
    begin
        item.opcode  = opcode;
        item.year_hi = year_hi;
        item.year_lo = year_rem[6:0];
        if (load_month == 4'd0) begin
            item.month = 4'd1;
        end else if (load_month > MONTH_MAX) begin
            item.month = MONTH_MAX;
        end else begin
            item.month = load_month;
        end
        item.day    = (load_day == 5'd0) ? 5'd1 : load_day;
        item.hour   = (load_hour > HOUR_MAX) ? HOUR_MAX : load_hour;
        item.minute = (load_minute > MINSEC_MAX) ? MINSEC_MAX : load_minute;
        item.second = (load_second > MINSEC_MAX) ? MINSEC_MAX : load_second;
    end

endmodule

// ===== rtl/ccbcd_cfg_regs.sv =====
// APB-style configuration register: ticks per second.
// Uses ccbcd_pkg.
`timescale 1ns / 1ps

module ccbcd_cfg_regs
    import ccbcd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output logic [7:0]  tps
);

    logic [7:0] tps_reg;
    logic [7:0] tps_next;
    logic       hit;

    assign hit    = (paddr == REG_TPS_ADDR);
    assign pready = 1'b1;
    assign prdata = hit ? {24'b0, tps_reg} : 32'b0;
    assign tps    = tps_reg;

    always_comb
    begin
        tps_next = tps_reg;
        if (psel && penable && pwrite && hit) begin
            tps_next = pwdata[7:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            tps_reg <= TPS_RESET;
        end else begin
            tps_reg <= tps_next;
        end
    end

endmodule

// ===== rtl/ccbcd_core.sv =====
// Calendar core: prescaler, BCD time counters with Gregorian month lengths,
// and the result valid flag. Uses ccbcd_pkg and the assertion macros.
`timescale 1ns / 1ps
`include "calendar_clock_bcd_unit_macros.svh"

module ccbcd_core
    import ccbcd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic [7:0]  tps,
    input  logic        item_valid,
    input  ccbcd_load_t item,
    input  logic        out_stall,
    output logic        hold,
    output logic        out_valid,
    output ccbcd_time_t out_time
);

    ccbcd_time_t cur_reg;
    ccbcd_time_t cur_next;
    ccbcd_time_t adv_time;
    ccbcd_time_t load_time;
    logic [7:0]  tick_count_reg;
    logic [7:0]  tick_count_next;
    logic        out_valid_reg;
    logic        out_valid_next;
    logic        fire;
    logic [7:0]  limit;
    logic [8:0]  tick_sum;
    logic        sec_done;

    // Result register full and not taken: freeze everything.
    assign hold      = out_valid_reg && out_stall;
    assign fire      = item_valid && !hold;
    assign out_valid = out_valid_reg;
    assign out_time  = cur_reg;

    assign limit    = (tps == 8'd0) ? 8'd1 : tps;
    assign tick_sum = {1'b0, tick_count_reg} + 9'd1;
    assign sec_done = (tick_sum >= {1'b0, limit});

    always_comb
    begin
        load_time.year   = {bin_to_bcd2(item.year_hi), bin_to_bcd2(item.year_lo)};
        load_time.month  = bin_to_bcd2({3'b0, item.month});
        load_time.day    = bin_to_bcd2({2'b0, item.day});
        load_time.hour   = bin_to_bcd2({2'b0, item.hour});
        load_time.minute = bin_to_bcd2({1'b0, item.minute});
        load_time.second = bin_to_bcd2({1'b0, item.second});
    end

    // One-second cascade.
    always_comb
    begin
        adv_time = cur_reg;
        if (cur_reg.second != 8'h59) begin
            adv_time.second = bcd_inc2(cur_reg.second);
        end else begin
            adv_time.second = 8'h00;
            if (cur_reg.minute != 8'h59) begin
                adv_time.minute = bcd_inc2(cur_reg.minute);
            end else begin
                adv_time.minute = 8'h00;
                if (cur_reg.hour != 8'h23) begin
                    adv_time.hour = bcd_inc2(cur_reg.hour);
                end else begin
                    adv_time.hour = 8'h00;
                    // packed BCD orders like binary; an overlong day falls to 1
                    if (cur_reg.day < month_days(cur_reg.month, is_leap(cur_reg.year))) begin
                        adv_time.day = bcd_inc2(cur_reg.day);
                    end else begin
                        adv_time.day = 8'h01;
                        if (cur_reg.month != 8'h12) begin
                            adv_time.month = bcd_inc2(cur_reg.month);
                        end else begin
                            adv_time.month = 8'h01;
                            adv_time.year  = (cur_reg.year == 16'h9999) ? 16'h0000
                                                                        : bcd_inc4(cur_reg.year);
                        end
                    end
                end
            end
        end
    end

    always_comb
    begin
        cur_next        = cur_reg;
        tick_count_next = tick_count_reg;
        out_valid_next  = hold;
        if (fire) begin
            if (item.opcode == OP_LOAD) begin
                cur_next        = load_time;
                tick_count_next = 8'd0;
                out_valid_next  = 1'b1;
            end else if (sec_done) begin
                cur_next        = adv_time;
                tick_count_next = 8'd0;
                out_valid_next  = 1'b1;
            end else begin
                tick_count_next = tick_sum[7:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            cur_reg        <= '{year: 16'h0000, month: 8'h01, day: 8'h01,
                                hour: 8'h00, minute: 8'h00, second: 8'h00};
            tick_count_reg <= 8'd0;
            out_valid_reg  <= 1'b0;
        end else begin
            cur_reg        <= cur_next;
            tick_count_reg <= tick_count_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    `CCBCD_ASSERT_ALWAYS(a_month_range, (cur_reg.month >= 8'h01) && (cur_reg.month <= 8'h12), "month out of range")
    `CCBCD_ASSERT_IMPLIES(a_day_nonzero, out_valid_reg, cur_reg.day != 8'h00, "day is zero")
    `CCBCD_ASSERT_NEXT(a_load_result, fire && (item.opcode == OP_LOAD), out_valid_reg, "load gave no result")
    `CCBCD_ASSERT_NEXT(a_hold_freeze, hold, $stable(cur_reg) && $stable(tick_count_reg), "state moved while held")

endmodule

// ===== rtl/calendar_clock_bcd_unit.sv =====
// Calendar clock top level: request register, load preparation, core, config port.
// Loads and ticks ending a second give results; other ticks step the prescaler.
// Throughput: one request per cycle; in_stall only while a result waits stalled.
// Reset (rst_n, async low): 0000-01-01 00:00:00, prescaler 0, 4 ticks per second.
// Each tick or load passes input register, one calendar update, result register.
`timescale 1ns / 1ps

module calendar_clock_bcd_unit
    import ccbcd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        opcode,
    input  logic [13:0] load_year,
    input  logic [3:0]  load_month,
    input  logic [4:0]  load_day,
    input  logic [4:0]  load_hour,
    input  logic [5:0]  load_minute,
    input  logic [5:0]  load_second,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [15:0] bcd_year,
    output logic [7:0]  bcd_month,
    output logic [7:0]  bcd_day,
    output logic [7:0]  bcd_hour,
    output logic [7:0]  bcd_minute,
    output logic [7:0]  bcd_second
);

    ccbcd_load_t prep_item;
    ccbcd_load_t req_reg;
    ccbcd_load_t req_next;
    logic        req_valid_reg;
    logic        req_valid_next;
    logic        hold;
    logic [7:0]  tps;
    ccbcd_time_t out_time;

    ccbcd_cfg_regs u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .tps     (tps)
    );

    ccbcd_load_prep u_prep (
        .opcode      (opcode),
        .load_year   (load_year),
        .load_month  (load_month),
        .load_day    (load_day),
        .load_hour   (load_hour),
        .load_minute (load_minute),
        .load_second (load_second),
        .item        (prep_item)
    );

    assign in_stall = hold;

    always_comb
    begin
        req_valid_next = req_valid_reg;
        req_next       = req_reg;
        if (!hold) begin
            req_valid_next = in_valid;
            if (in_valid) begin
                req_next = prep_item;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            req_valid_reg <= 1'b0;
        end else begin
            req_valid_reg <= req_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg <= req_next;
    end

    ccbcd_core u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .tps        (tps),
        .item_valid (req_valid_reg),
        .item       (req_reg),
        .out_stall  (out_stall),
        .hold       (hold),
        .out_valid  (out_valid),
        .out_time   (out_time)
    );

    assign bcd_year   = out_time.year;
    assign bcd_month  = out_time.month;
    assign bcd_day    = out_time.day;
    assign bcd_hour   = out_time.hour;
    assign bcd_minute = out_time.minute;
    assign bcd_second = out_time.second;

endmodule

// ===== tb/sv/calendar_checker.sv =====
// Checker for the calendar clock: predicts the BCD date and time for each load and each
// completed second; checks results in order. Needs ccbcd_pkg for codes and result type.
`timescale 1ns / 1ps

module calendar_checker
    import ccbcd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic [31:0] prdata,
    input  logic        pready,
    input  logic        in_valid,
    input  logic        in_stall,
    input  logic        opcode,
    input  logic [13:0] load_year,
    input  logic [3:0]  load_month,
    input  logic [4:0]  load_day,
    input  logic [4:0]  load_hour,
    input  logic [5:0]  load_minute,
    input  logic [5:0]  load_second,
    input  logic        out_valid,
    input  logic        out_stall,
    input  logic [15:0] bcd_year,
    input  logic [7:0]  bcd_month,
    input  logic [7:0]  bcd_day,
    input  logic [7:0]  bcd_hour,
    input  logic [7:0]  bcd_minute,
    input  logic [7:0]  bcd_second,
    output int          pending_times,
    output int          error_count
);

    logic [7:0]  rate;
    logic [7:0]  prescale;
    logic [13:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;

    ccbcd_time_t expected_times[$];

    function automatic logic [7:0] two_digits(input int v);
        return {4'((v / 10) % 10), 4'(v % 10)};
    endfunction

    function automatic int month_length(input int y, input int m);
        int len;
        case (m)
            4, 6, 9, 11: len = 30;
            2:           len = (((y % 4) == 0 && (y % 100) != 0) || (y % 400) == 0) ? 29 : 28;
            default:     len = 31;
        endcase
        return len;
    endfunction

    function automatic ccbcd_time_t calendar_bcd();
        ccbcd_time_t t;
        int y;
        y = int'(year);
        t.year   = {4'(y / 1000), 4'((y / 100) % 10), 4'((y / 10) % 10), 4'(y % 10)};
        t.month  = two_digits(int'(month));
        t.day    = two_digits(int'(day));
        t.hour   = two_digits(int'(hour));
        t.minute = two_digits(int'(minute));
        t.second = two_digits(int'(second));
        return t;
    endfunction

    // Cascade of rollovers; a day past the month length goes straight to the 1st.
    function automatic void advance_second();
        if (second < MINSEC_MAX) begin
            second = second + 6'd1;
        end else begin
            second = '0;
            if (minute < MINSEC_MAX) begin
                minute = minute + 6'd1;
            end else begin
                minute = '0;
                if (hour < HOUR_MAX) begin
                    hour = hour + 5'd1;
                end else begin
                    hour = '0;
                    if (int'(day) < month_length(int'(year), int'(month))) begin
                        day = day + 5'd1;
                    end else begin
                        day = 5'd1;
                        if (month < MONTH_MAX) begin
                            month = month + 4'd1;
                        end else begin
                            month = 4'd1;
                            year  = (year >= YEAR_MAX) ? '0 : year + 14'd1;
                        end
                    end
                end
            end
        end
    endfunction

    task automatic check_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
        if (got !== want) begin
            $error("%s: expected %h, got %h", name, want, got);
            error_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n) begin : predict_and_compare
        ccbcd_time_t want;
        int          limit;
        if (!rst_n) begin
            rate        = TPS_RESET;
            prescale    = '0;
            year        = '0;
            month       = 4'd1;
            day         = 5'd1;
            hour        = '0;
            minute      = '0;
            second      = '0;
            error_count = 0;
            expected_times.delete();
        end else begin
            if (psel && penable && pready && paddr == REG_TPS_ADDR) begin
                if (pwrite) begin
                    rate = pwdata[7:0];
                end else begin
                    check_field("prdata", {8'd0, rate}, {8'd0, prdata[7:0]});
                end
            end

            if (out_valid && !out_stall) begin
                if (expected_times.size() == 0) begin
                    $error("result %h with no request pending", bcd_year);
                    error_count++;
                end else begin
                    want = expected_times.pop_front();
                    check_field("bcd_year",   want.year,           bcd_year);
                    check_field("bcd_month",  {8'd0, want.month},  {8'd0, bcd_month});
                    check_field("bcd_day",    {8'd0, want.day},    {8'd0, bcd_day});
                    check_field("bcd_hour",   {8'd0, want.hour},   {8'd0, bcd_hour});
                    check_field("bcd_minute", {8'd0, want.minute}, {8'd0, bcd_minute});
                    check_field("bcd_second", {8'd0, want.second}, {8'd0, bcd_second});
                end
            end

            if (in_valid && !in_stall) begin
                if (opcode == OP_LOAD) begin
                    year     = (load_year > YEAR_MAX) ? YEAR_MAX : load_year;
                    month    = (load_month == 4'd0) ? 4'd1 :
                               (load_month > MONTH_MAX) ? MONTH_MAX : load_month;
                    day      = (load_day == 5'd0) ? 5'd1 : load_day;
                    hour     = (load_hour > HOUR_MAX) ? HOUR_MAX : load_hour;
                    minute   = (load_minute > MINSEC_MAX) ? MINSEC_MAX : load_minute;
                    second   = (load_second > MINSEC_MAX) ? MINSEC_MAX : load_second;
                    prescale = '0;
                    expected_times.push_back(calendar_bcd());
                end else begin
                    // zero rate counts as one; a count at or past the rate completes
                    limit = (rate == 8'd0) ? 1 : int'(rate);
                    if (int'(prescale) + 1 < limit) begin
                        prescale = prescale + 8'd1;
                    end else begin
                        prescale = '0;
                        advance_second();
                        expected_times.push_back(calendar_bcd());
                    end
                end
            end
        end
        pending_times = expected_times.size();
    end

endmodule

// ===== tb/sv/tb_top.sv =====
// Top of the calendar clock testbench: clock, reset, register writes and requests.
// Depends on calendar_clock_bcd_unit, calendar_checker and ccbcd_pkg.
`timescale 1ns / 1ps

module tb_top;
    import ccbcd_pkg::*;

    localparam logic [2:0] UNUSED_ADDR  = 3'd4;
    localparam int         DRAIN_CYCLES = 8;
    localparam int         CYCLE_LIMIT  = 200000;

    logic        clk         = 1'b0;
    logic        rst_n       = 1'b0;
    logic        psel        = 1'b0;
    logic        penable     = 1'b0;
    logic        pwrite      = 1'b0;
    logic [2:0]  paddr       = '0;
    logic [31:0] pwdata      = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        in_valid    = 1'b0;
    logic        in_stall;
    logic        opcode      = OP_TICK;
    logic [13:0] load_year   = '0;
    logic [3:0]  load_month  = '0;
    logic [4:0]  load_day    = '0;
    logic [4:0]  load_hour   = '0;
    logic [5:0]  load_minute = '0;
    logic [5:0]  load_second = '0;
    logic        out_valid;
    logic        out_stall   = 1'b0;
    logic [15:0] bcd_year;
    logic [7:0]  bcd_month;
    logic [7:0]  bcd_day;
    logic [7:0]  bcd_hour;
    logic [7:0]  bcd_minute;
    logic [7:0]  bcd_second;

    logic idle_on = 1'b1;
    int   pending_times;
    int   error_count;
    int   cycles = 0;

    calendar_clock_bcd_unit i_dut (
        .clk(clk), .rst_n(rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .in_valid(in_valid), .in_stall(in_stall), .opcode(opcode),
        .load_year(load_year), .load_month(load_month), .load_day(load_day),
        .load_hour(load_hour), .load_minute(load_minute), .load_second(load_second),
        .out_valid(out_valid), .out_stall(out_stall),
        .bcd_year(bcd_year), .bcd_month(bcd_month), .bcd_day(bcd_day),
        .bcd_hour(bcd_hour), .bcd_minute(bcd_minute), .bcd_second(bcd_second)
    );

    calendar_checker i_checker (
        .clk(clk), .rst_n(rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .in_valid(in_valid), .in_stall(in_stall), .opcode(opcode),
        .load_year(load_year), .load_month(load_month), .load_day(load_day),
        .load_hour(load_hour), .load_minute(load_minute), .load_second(load_second),
        .out_valid(out_valid), .out_stall(out_stall),
        .bcd_year(bcd_year), .bcd_month(bcd_month), .bcd_day(bcd_day),
        .bcd_hour(bcd_hour), .bcd_minute(bcd_minute), .bcd_second(bcd_second),
        .pending_times(pending_times), .error_count(error_count)
    );

    initial begin
        forever #1 clk = ~clk;
    end

    always @(posedge clk) begin
        out_stall <= idle_on && ($urandom_range(99) < 21);
    end

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // Called right after a rising edge; returns right after the edge that took the request.
    task automatic send_request(input logic op, input logic [13:0] y, input logic [3:0] mo,
                                input logic [4:0] d, input logic [4:0] h,
                                input logic [5:0] mi, input logic [5:0] s);
        while (idle_on && $urandom_range(99) < 21) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid    <= 1'b1;
        opcode      <= op;
        load_year   <= y;
        load_month  <= mo;
        load_day    <= d;
        load_hour   <= h;
        load_minute <= mi;
        load_second <= s;
        do @(posedge clk); while (in_stall);
    endtask

    // load fields still toggle on ticks, the block must ignore them
    task automatic tick();
        send_request(OP_TICK, 14'($urandom), 4'($urandom), 5'($urandom), 5'($urandom),
                     6'($urandom), 6'($urandom));
    endtask

    task automatic load(input int y, input int mo, input int d, input int h,
                        input int mi, input int s);
        send_request(OP_LOAD, 14'(y), 4'(mo), 5'(d), 5'(h), 6'(mi), 6'(s));
    endtask

    // Mostly dates close to a rollover; the rest is raw bits, out of range included.
    task automatic load_random();
        int y;
        int mo;
        if ($urandom_range(99) < 25) begin
            load($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
        end else begin
            case ($urandom_range(4))
                0:       y = $urandom_range(24) * 400;
                1:       y = $urandom_range(99) * 100;
                2:       y = $urandom_range(2499) * 4;
                3:       y = 9999;
                default: y = $urandom_range(9999);
            endcase
            mo = ($urandom_range(1) == 0) ? (($urandom_range(1) == 0) ? 2 : 12)
                                          : $urandom_range(1, 12);
            load(y, mo, $urandom_range(27, 31),
                 ($urandom_range(1) == 0) ? 23 : $urandom_range(23),
                 ($urandom_range(1) == 0) ? 59 : $urandom_range(59),
                 $urandom_range(55, 59));
        end
    endtask

    // Sender pauses until every result is back, then lets in-flight ticks settle.
    task automatic wait_idle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_times != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Write then read back in one transfer pair; psel stays high between them.
    task automatic set_rate(input logic [2:0] addr, input logic [7:0] value);
        logic [31:0] word;
        word      = $urandom;
        word[7:0] = value;
        wait_idle();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= word;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic run_phase(input int count, input int load_pct);
        for (int i = 0; i < count; i++) begin
            if (i == count / 2) wait_idle();
            if ($urandom_range(99) < load_pct) load_random();
            else tick();
        end
    endtask

    initial begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset rate of four ticks; a load restarts the prescaler
        repeat (4) tick();
        tick();
        load(2023, 2, 31, 23, 59, 59);
        repeat (4) tick();

        set_rate(REG_TPS_ADDR, 8'd1);
        load(9999, 12, 31, 23, 59, 59);
        tick();
        load(16383, 15, 31, 31, 63, 63);
        load(0, 0, 0, 0, 0, 0);
        load(2000, 2, 28, 23, 59, 59);
        tick();
        load(1900, 2, 28, 23, 59, 59);
        tick();

        set_rate(REG_TPS_ADDR, 8'd0);
        tick();

        // prescaler left above a lowered rate
        set_rate(REG_TPS_ADDR, 8'd255);
        repeat (5) tick();
        set_rate(REG_TPS_ADDR, 8'd3);
        tick();

        set_rate(UNUSED_ADDR, 8'd1);
        run_phase(100, 30);

        set_rate(REG_TPS_ADDR, 8'd1);
        idle_on <= 1'b0;
        run_phase(100, 25);
        wait_idle();
        idle_on <= 1'b1;

        set_rate(REG_TPS_ADDR, 8'd2);
        run_phase(80, 25);
        set_rate(REG_TPS_ADDR, 8'd0);
        run_phase(60, 25);

        set_rate(REG_TPS_ADDR, 8'd255);
        repeat (256) tick();
        run_phase(20, 30);

        set_rate(REG_TPS_ADDR, 8'($urandom_range(4, 16)));
        run_phase(80, 20);
        set_rate(REG_TPS_ADDR, 8'd1);
        run_phase(40, 40);

        wait_idle();
        if (error_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
